// ===== hw/rtl/mwnw_pkg.sv =====
// ----------------------------------------------------------------------------
// mwnw_pkg: shared types and constants
// Word formats and fixed constants of the mission window nearest waypoint block.
// ----------------------------------------------------------------------------
package mwnw_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSPECTION_STATE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE = 2'd2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [15:0] RADIUS_RESET = 16'd3840;
   localparam logic [11:0] WINDOW_RESET = 12'd200;
   localparam int FIRST_START = 5;
   localparam int BACK_OFF = 4;
   localparam logic [4:0] AHEAD_MAX = 5'd2;
   localparam logic [4:0] END_ALT_DIFF = 5'd6;
   localparam int RESCAN_LAST = 200;
   localparam int TAIL_GUARD = 4;

   typedef struct packed {
      logic kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [3:0] point_state;
   } req_type;

   typedef struct packed {
      logic found;
      logic [11:0] closest_index;
      logic [3:0] op_state;
      logic [15:0] nearest_dist;
      logic [31:0] next_state_dist;
      logic [11:0] window_first_count;
      logic index_error;
   } rsp_type;

endpackage

// ===== hw/rtl/mwnw_ram.sv =====
// ----------------------------------------------------------------------------
// mwnw_ram: generic single-port-write RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module mwnw_ram #(
   parameter int WIDTH = 68,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// ===== hw/rtl/mwnw_isqrt.sv =====
// ----------------------------------------------------------------------------
// mwnw_isqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module mwnw_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      v_in = v_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      trial = r_ff + bit_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 5'd0;
         v_in = value;
         r_in = 64'd0;
         bit_in = 64'd1 << 62;
      end else if (run_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      v_ff <= v_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

// ===== hw/rtl/mission_window_nearest_waypoint.sv =====
// ----------------------------------------------------------------------------
// mission_window_nearest_waypoint: nearest waypoint in the mission window
// Waypoint table with mission states and a query that finds the nearest
// waypoint, the new mission state and the distance to the next state start.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A load word (kind 0)
// appends one waypoint in that cycle (none once the table is full) and
// gives no result; busy stays low. A query word (kind 1) raises busy until
// its result word is shown on rsp_data for one cycle with rsp_valid high;
// busy falls in that cycle. A query streams the waypoint memory through a
// three-stage distance pipe, one entry per cycle, from the current state's
// start minus four to the table end (earlier if the points move out of
// range), plus entries 1 to 200 in the end state. It then takes the root
// of the nearest distance when one was found, reads the window head and the
// next state's start, squares the target offsets and roots their sum.
// Configuration writes on the csr port take effect at once.
// Reset empties the table, loads the register reset values and leaves the
// block idle. The receiver cannot stall; each result is shown once.
// ----------------------------------------------------------------------------
module mission_window_nearest_waypoint #(
   parameter int MAX_WAYPOINTS = 4096,
   parameter int MAX_STATES = 16,
   parameter int END_STATE = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  mwnw_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   output mwnw_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [mwnw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mwnw_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int AW = $clog2(MAX_WAYPOINTS);
   localparam int CW = AW + 1;
   localparam int SW = $clog2(MAX_STATES);
   localparam int SCW = SW + 1;
   localparam int LW = (CW + 1 > 13) ? CW + 1 : 13;
   localparam int DW = 68;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SQRT_BEST, S_HEAD, S_HEAD_WAIT, S_TARGET,
      S_TARGET_WAIT, S_MULT, S_SUM, S_SQRT_TGT, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]  tc_ff, tc_in;
   logic [SCW-1:0] sc_ff, sc_in;
   logic [3:0]     last_ls_ff, last_ls_in;
   logic [3:0]     cur_ff, cur_in;
   logic [AW-1:0]  closest_ff, closest_in;
   logic           ever_ff, ever_in;
   logic [15:0]    radius_ff, radius_in;
   logic [3:0]     insp_ff, insp_in;
   logic [11:0]    wsize_ff, wsize_in;
   logic [AW-1:0]  starts_ff [MAX_STATES];
   logic [AW-1:0]  starts_in [MAX_STATES];

   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic [31:0]    r2_ff, r2_in;
   logic           err_ff, err_in;
   logic           found_ff, found_in;
   logic [AW-1:0]  best_ff, best_in;
   logic [31:0]    bestd2_ff, bestd2_in;
   logic [15:0]    ndist_ff, ndist_in;
   logic [11:0]    cnt_ff, cnt_in;
   logic [31:0]    nd_ff, nd_in;

   logic           issue_ff, issue_in;
   logic           phase_ff, phase_in;
   logic           stop_ff, stop_in;
   logic [AW-1:0]  ix_ff, ix_in;
   logic [AW-1:0]  last_ff, last_in;
   logic           a_v_ff, a_v_in;
   logic [AW-1:0]  a_idx_ff, a_idx_in;
   logic           b_v_ff, b_v_in;
   logic [AW-1:0]  b_idx_ff, b_idx_in;
   logic [15:0]    b_ax_ff, b_ax_in, b_ay_ff, b_ay_in;
   logic           b_sat_ff, b_sat_in, b_ok_ff, b_ok_in, b_far_ff, b_far_in;
   logic           c_v_ff, c_v_in;
   logic [AW-1:0]  c_idx_ff, c_idx_in;
   logic [31:0]    c_sqx_ff, c_sqx_in, c_sqy_ff, c_sqy_in;
   logic           c_sat_ff, c_sat_in, c_ok_ff, c_ok_in, c_far_ff, c_far_in;

   logic [63:0]    mx_acc_ff, mx_acc_in, my_acc_ff, my_acc_in;
   logic [63:0]    mx_mc_ff, mx_mc_in, my_mc_ff, my_mc_in;
   logic [31:0]    mx_mp_ff, mx_mp_in, my_mp_ff, my_mp_in;
   logic [4:0]     mcnt_ff, mcnt_in;

   logic           rsp_valid_ff, rsp_valid_in;
   mwnw_pkg::rsp_type rsp_ff, rsp_in;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [DW-1:0]  ram_wdata, ram_rdata;

   logic           sq_start, sq_done;
   logic [63:0]    sq_value;
   logic [31:0]    sq_root;

   logic [31:0]    wx, wy;
   logic [3:0]     ws;
   logic [32:0]    dx, dy, adx, ady;
   logic           is_end, ok_now, far_now, accept;
   logic [32:0]    d2;
   logic           less, greater;
   logic [AW:0]    look, look_next;
   logic [AW-1:0]  st_idx, from_idx, tgt, head, rescan_last;
   logic [4:0]     next_s;
   logic signed [LW-1:0] lim, room;
   logic           head_ok;
   logic [64:0]    sum;
   logic [3:0]     new_state;

   function automatic logic [AW:0] start_lookup(input logic [4:0] s,
                                                input logic [SCW-1:0] count,
                                                input logic [CW-1:0] tcount,
                                                input logic [AW-1:0] entry);
      logic [AW-1:0] fallback;
      fallback = (tcount != '0) ? AW'(tcount - CW'(1)) : '0;
      if (7'(s) < 7'(count) && 7'(s) < 7'(MAX_STATES)) begin
         return {1'b0, entry};
      end
      return {1'b1, fallback};
   endfunction

   mwnw_ram #(
      .WIDTH(DW),
      .DEPTH(MAX_WAYPOINTS)
   ) u_table (
      .clock(clock),
      .write_enable(ram_we),
      .write_address(ram_waddr),
      .write_data(ram_wdata),
      .read_address(ram_raddr),
      .read_data(ram_rdata)
   );

   mwnw_isqrt u_isqrt (
      .clock(clock),
      .reset(reset),
      .start(sq_start),
      .value(sq_value),
      .done(sq_done),
      .root(sq_root)
   );

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign is_end = (cur_ff == 4'(END_STATE));

   always_comb begin
      wx = ram_rdata[31:0];
      wy = ram_rdata[63:32];
      ws = ram_rdata[67:64];
      dx = {px_ff[31], px_ff} - {wx[31], wx};
      dy = {py_ff[31], py_ff} - {wy[31], wy};
      adx = dx[32] ? (~dx + 33'd1) : dx;
      ady = dy[32] ? (~dy + 33'd1) : dy;
      if (is_end) begin
         ok_now = (ws == cur_ff) ||
                  ({1'b0, ws} == {1'b0, cur_ff} + mwnw_pkg::END_ALT_DIFF) ||
                  ({1'b0, ws} + mwnw_pkg::END_ALT_DIFF == {1'b0, cur_ff});
      end else begin
         ok_now = (ws >= cur_ff) &&
                  ({1'b0, ws} <= {1'b0, cur_ff} + mwnw_pkg::AHEAD_MAX);
      end
      far_now = {1'b0, ws} > {1'b0, cur_ff} + mwnw_pkg::AHEAD_MAX;
      d2 = {1'b0, c_sqx_ff} + {1'b0, c_sqy_ff};
      less = !c_sat_ff && (d2 < {1'b0, r2_ff});
      greater = c_sat_ff || (d2 > {1'b0, r2_ff});
      lim = LW'(tc_ff) - LW'(mwnw_pkg::TAIL_GUARD);
      room = lim - LW'(closest_ff);
      head_ok = $signed(LW'(closest_ff)) < lim;
      head = head_ok ? closest_ff : AW'(1);
      rescan_last = (tc_ff - CW'(1) > CW'(mwnw_pkg::RESCAN_LAST)) ?
                    AW'(mwnw_pkg::RESCAN_LAST) : AW'(tc_ff - CW'(1));
      look = start_lookup({1'b0, cur_ff}, sc_ff, tc_ff, starts_ff[SW'(cur_ff)]);
      st_idx = look[AW-1:0];
      from_idx = (st_idx >= AW'(mwnw_pkg::BACK_OFF)) ?
                 st_idx - AW'(mwnw_pkg::BACK_OFF) : '0;
      next_s = is_end ? 5'd0 : {1'b0, cur_ff} + 5'd1;
      sum = {1'b0, mx_acc_ff} + {1'b0, my_acc_ff};
   end

   always_comb begin
      state_in = state_ff;
      tc_in = tc_ff;
      sc_in = sc_ff;
      last_ls_in = last_ls_ff;
      cur_in = cur_ff;
      closest_in = closest_ff;
      ever_in = ever_ff;
      radius_in = radius_ff;
      insp_in = insp_ff;
      wsize_in = wsize_ff;
      starts_in = starts_ff;
      px_in = px_ff;
      py_in = py_ff;
      r2_in = r2_ff;
      err_in = err_ff;
      found_in = found_ff;
      best_in = best_ff;
      bestd2_in = bestd2_ff;
      ndist_in = ndist_ff;
      cnt_in = cnt_ff;
      nd_in = nd_ff;
      issue_in = issue_ff;
      phase_in = phase_ff;
      stop_in = stop_ff;
      ix_in = ix_ff;
      last_in = last_ff;
      a_v_in = 1'b0;
      a_idx_in = ix_ff;
      b_v_in = a_v_ff;
      b_idx_in = a_idx_ff;
      b_ax_in = adx[15:0];
      b_ay_in = ady[15:0];
      b_sat_in = (|adx[32:16]) || (|ady[32:16]);
      b_ok_in = ok_now;
      b_far_in = far_now;
      c_v_in = b_v_ff;
      c_idx_in = b_idx_ff;
      c_sqx_in = b_ax_ff * b_ax_ff;
      c_sqy_in = b_ay_ff * b_ay_ff;
      c_sat_in = b_sat_ff;
      c_ok_in = b_ok_ff;
      c_far_in = b_far_ff;
      mx_acc_in = mx_acc_ff;
      my_acc_in = my_acc_ff;
      mx_mc_in = mx_mc_ff;
      my_mc_in = my_mc_ff;
      mx_mp_in = mx_mp_ff;
      my_mp_in = my_mp_ff;
      mcnt_in = mcnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      ram_we = 1'b0;
      ram_waddr = tc_ff[AW-1:0];
      ram_wdata = {req_data.point_state, req_data.pos_y, req_data.pos_x};
      ram_raddr = ix_ff;
      sq_start = 1'b0;
      sq_value = {32'd0, bestd2_ff};
      look_next = '0;
      tgt = '0;
      new_state = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.kind == mwnw_pkg::KIND_LOAD) begin
               if (tc_ff < CW'(MAX_WAYPOINTS)) begin
                  ram_we = 1'b1;
                  if (req_data.point_state != last_ls_ff && sc_ff < SCW'(MAX_STATES)) begin
                     starts_in[sc_ff[SW-1:0]] = tc_ff[AW-1:0];
                     sc_in = sc_ff + SCW'(1);
                  end
                  last_ls_in = req_data.point_state;
                  tc_in = tc_ff + CW'(1);
               end
            end else if (accept) begin
               px_in = req_data.pos_x;
               py_in = req_data.pos_y;
               r2_in = radius_ff * radius_ff;
               err_in = look[AW];
               found_in = 1'b0;
               stop_in = 1'b0;
               ndist_in = 16'd0;
               cnt_in = 12'd0;
               phase_in = 1'b0;
               if (CW'(from_idx) < tc_ff) begin
                  issue_in = 1'b1;
                  ix_in = from_idx;
                  last_in = AW'(tc_ff - CW'(1));
               end else if (is_end && tc_ff > CW'(1)) begin
                  issue_in = 1'b1;
                  phase_in = 1'b1;
                  ix_in = AW'(1);
                  last_in = rescan_last;
               end else begin
                  issue_in = 1'b0;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff && !stop_ff) begin
               a_v_in = 1'b1;
               if (ix_ff == last_ff) begin
                  if (!phase_ff && is_end && tc_ff > CW'(1)) begin
                     phase_in = 1'b1;
                     ix_in = AW'(1);
                     last_in = rescan_last;
                  end else begin
                     issue_in = 1'b0;
                  end
               end else begin
                  ix_in = ix_ff + AW'(1);
               end
            end else begin
               issue_in = 1'b0;
            end
            if (c_v_ff && !stop_ff) begin
               if (less && c_ok_ff && (!found_ff || d2[31:0] < bestd2_ff)) begin
                  found_in = 1'b1;
                  best_in = c_idx_ff;
                  bestd2_in = d2[31:0];
               end
               if (!is_end && greater && c_far_ff) begin
                  stop_in = 1'b1;
               end
            end
            if (!issue_ff && !a_v_ff && !b_v_ff && !c_v_ff) begin
               if (found_ff) begin
                  sq_start = 1'b1;
                  closest_in = best_ff;
                  ever_in = 1'b1;
                  state_in = S_SQRT_BEST;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_SQRT_BEST: begin
            if (sq_done) begin
               ndist_in = sq_root[15:0];
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (head_ok) begin
               cnt_in = (room < $signed(LW'(wsize_ff))) ? 12'(room) : wsize_ff;
            end
            ram_raddr = head;
            if (wsize_ff != 12'd0 && CW'(head) < tc_ff) begin
               state_in = S_HEAD_WAIT;
            end else begin
               cur_in = ever_ff ? cur_ff : insp_ff;
               state_in = S_TARGET;
            end
         end
         S_HEAD_WAIT: begin
            new_state = ws;
            cur_in = ever_ff ? new_state : insp_ff;
            state_in = S_TARGET;
         end
         S_TARGET: begin
            look_next = start_lookup(next_s, sc_ff, tc_ff, starts_ff[SW'(next_s)]);
            tgt = look_next[AW-1:0];
            err_in = err_ff | look_next[AW];
            if (tc_ff == '0) begin
               err_in = 1'b1;
               nd_in = 32'd0;
               state_in = S_DONE;
            end else begin
               if (CW'(tgt) >= tc_ff) begin
                  tgt = AW'(tc_ff - CW'(1));
                  err_in = 1'b1;
               end
               ram_raddr = tgt;
               state_in = S_TARGET_WAIT;
            end
         end
         S_TARGET_WAIT: begin
            mx_acc_in = 64'd0;
            my_acc_in = 64'd0;
            mx_mc_in = {32'd0, adx[31:0]};
            my_mc_in = {32'd0, ady[31:0]};
            mx_mp_in = adx[31:0];
            my_mp_in = ady[31:0];
            mcnt_in = 5'd0;
            state_in = S_MULT;
         end
         S_MULT: begin
            if (mx_mp_ff[0]) begin
               mx_acc_in = mx_acc_ff + mx_mc_ff;
            end
            if (my_mp_ff[0]) begin
               my_acc_in = my_acc_ff + my_mc_ff;
            end
            mx_mc_in = mx_mc_ff << 1;
            my_mc_in = my_mc_ff << 1;
            mx_mp_in = mx_mp_ff >> 1;
            my_mp_in = my_mp_ff >> 1;
            mcnt_in = mcnt_ff + 5'd1;
            if (mcnt_ff == 5'd31) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (sum[64]) begin
               nd_in = 32'hFFFF_FFFF;
               state_in = S_DONE;
            end else begin
               sq_value = sum[63:0];
               sq_start = 1'b1;
               state_in = S_SQRT_TGT;
            end
         end
         S_SQRT_TGT: begin
            if (sq_done) begin
               nd_in = sq_root;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.found = found_ff;
            rsp_in.closest_index = 12'(closest_ff);
            rsp_in.op_state = cur_ff;
            rsp_in.nearest_dist = ndist_ff;
            rsp_in.next_state_dist = nd_ff;
            rsp_in.window_first_count = cnt_ff;
            rsp_in.index_error = err_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         unique case (csr_index)
            mwnw_pkg::CSR_SEARCH_RADIUS: begin
               radius_in = csr_data;
            end
            mwnw_pkg::CSR_INSPECTION_STATE: begin
               insp_in = csr_data[3:0];
               if (!ever_ff) begin
                  cur_in = csr_data[3:0];
               end
            end
            mwnw_pkg::CSR_WINDOW_SIZE: begin
               wsize_in = csr_data[11:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tc_ff <= '0;
         sc_ff <= SCW'(1);
         last_ls_ff <= 4'd0;
         cur_ff <= 4'd0;
         closest_ff <= '0;
         ever_ff <= 1'b0;
         radius_ff <= mwnw_pkg::RADIUS_RESET;
         insp_ff <= 4'd0;
         wsize_ff <= mwnw_pkg::WINDOW_RESET;
         for (int k = 0; k < MAX_STATES; k++) begin
            starts_ff[k] <= (k == 0) ? AW'(mwnw_pkg::FIRST_START) : '0;
         end
         issue_ff <= 1'b0;
         stop_ff <= 1'b0;
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tc_ff <= tc_in;
         sc_ff <= sc_in;
         last_ls_ff <= last_ls_in;
         cur_ff <= cur_in;
         closest_ff <= closest_in;
         ever_ff <= ever_in;
         radius_ff <= radius_in;
         insp_ff <= insp_in;
         wsize_ff <= wsize_in;
         starts_ff <= starts_in;
         issue_ff <= issue_in;
         stop_ff <= stop_in;
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         c_v_ff <= c_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff <= px_in;
      py_ff <= py_in;
      r2_ff <= r2_in;
      err_ff <= err_in;
      found_ff <= found_in;
      best_ff <= best_in;
      bestd2_ff <= bestd2_in;
      ndist_ff <= ndist_in;
      cnt_ff <= cnt_in;
      nd_ff <= nd_in;
      phase_ff <= phase_in;
      ix_ff <= ix_in;
      last_ff <= last_in;
      a_idx_ff <= a_idx_in;
      b_idx_ff <= b_idx_in;
      b_ax_ff <= b_ax_in;
      b_ay_ff <= b_ay_in;
      b_sat_ff <= b_sat_in;
      b_ok_ff <= b_ok_in;
      b_far_ff <= b_far_in;
      c_idx_ff <= c_idx_in;
      c_sqx_ff <= c_sqx_in;
      c_sqy_ff <= c_sqy_in;
      c_sat_ff <= c_sat_in;
      c_ok_ff <= c_ok_in;
      c_far_ff <= c_far_in;
      mx_acc_ff <= mx_acc_in;
      my_acc_ff <= my_acc_in;
      mx_mc_ff <= mx_mc_in;
      my_mc_ff <= my_mc_in;
      mx_mp_ff <= mx_mp_in;
      my_mp_ff <= my_mp_in;
      mcnt_ff <= mcnt_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while a query is still running");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == mwnw_pkg::KIND_QUERY) |=> busy)
      else $error("query word did not start a query");

   a_found_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.nearest_dist < radius_ff))
      else $error("nearest distance not inside the search radius");

   a_empty_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && tc_ff == '0) |-> rsp_data.index_error)
      else $error("empty table without index error");

   a_scan_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SCAN) |-> (!issue_ff || state_ff == S_IDLE) && !a_v_ff)
      else $error("scan pipe active outside the scan");

endmodule
